>>> design/imt_pkg.sv
// Shared constants, codes and interface types of the in-place transpose unit.
`default_nettype none
package imt_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(ADDR_W);
    localparam int IDX_W       = 10;
    localparam int DATA_W      = 64;
    localparam int RC_W        = 11;
    localparam int SIZE_W      = 2 * RC_W;

    localparam logic [1:0] ACT_WRITE     = 2'd0;
    localparam logic [1:0] ACT_READ      = 2'd1;
    localparam logic [1:0] ACT_TRANSPOSE = 2'd2;

    localparam logic [1:0] STAT_READ = 2'd0;
    localparam logic [1:0] STAT_DONE = 2'd1;
    localparam logic [1:0] STAT_SIZE = 2'd2;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_SIZE,
        S_CHECK,
        S_LEAD,
        S_DIV,
        S_MUL,
        S_SEARCH,
        S_HOLD_RD,
        S_HOLD,
        S_ROT_CHK,
        S_MOVE_WR,
        S_LAST_WR,
        S_NEXT
    } t_state;

    typedef enum logic [1:0] {
        W_INPUT,
        W_MOVE,
        W_HELD
    } t_wsel;

    typedef enum logic [1:0] {
        R_INPUT,
        R_LEAD,
        R_SRC
    } t_rsel;

    typedef struct packed {
        logic       mem_we;
        t_wsel      wsel;
        logic       rd_en;
        t_rsel      rsel;
        logic       cap_size;
        logic       lead_clr;
        logic       lead_inc;
        logic       div_load;
        logic       div_sel_lead;
        logic       div_step;
        logic       src_load;
        logic       dst_load_lead;
        logic       dst_load_src;
        logic       held_load;
        logic       emit;
        logic [1:0] emit_status;
    } t_dp_cmd;

    typedef struct packed {
        logic size_big;
        logic size_tiny;
        logic div_last;
        logic src_gt_lead;
        logic src_eq_lead;
        logic lead_last;
    } t_dp_stat;

endpackage
`default_nettype wire

>>> design/imt_dp.sv
// Datapath: element store, source-position divider, cycle registers and result registers.
`default_nettype none
module imt_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire imt_pkg::t_dp_cmd              i_cmd,
    output imt_pkg::t_dp_stat                  o_stat,
    input  wire logic [imt_pkg::RC_W-1:0]      i_rows,
    input  wire logic [imt_pkg::RC_W-1:0]      i_cols,
    input  wire logic [imt_pkg::IDX_W-1:0]     i_element_index,
    input  wire logic signed [imt_pkg::DATA_W-1:0] i_element_value,
    output logic                               o_strobe,
    output logic [1:0]                         o_status,
    output logic signed [imt_pkg::DATA_W-1:0]  o_read_value
);

    logic [imt_pkg::DATA_W-1:0] r_mem [imt_pkg::STORE_DEPTH];
    logic [imt_pkg::DATA_W-1:0] r_rdata;
    logic                       r_rd_ok;
    logic [imt_pkg::DATA_W-1:0] r_held;
    logic [imt_pkg::SIZE_W-1:0] r_size;
    logic [imt_pkg::ADDR_W-1:0] r_lead;
    logic [imt_pkg::ADDR_W-1:0] r_src;
    logic [imt_pkg::ADDR_W-1:0] r_dst;
    logic [imt_pkg::ADDR_W-1:0] r_dvd;
    logic [imt_pkg::ADDR_W-1:0] r_quo;
    logic [imt_pkg::RC_W-1:0]   r_rem;
    logic [imt_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_strobe;
    logic [1:0]                 r_status;
    logic [imt_pkg::DATA_W-1:0] r_value;

    logic                       idx_ok;
    logic                       we;
    logic [imt_pkg::ADDR_W-1:0] waddr;
    logic [imt_pkg::DATA_W-1:0] wdata;
    logic [imt_pkg::ADDR_W-1:0] raddr;
    logic [imt_pkg::RC_W:0]     trial;
    logic                       trial_ge;
    logic [imt_pkg::RC_W:0]     trial_sub;
    logic [imt_pkg::SIZE_W-1:0] src_next;

    assign idx_ok = 32'(i_element_index) < 32'(imt_pkg::STORE_DEPTH);

    always_comb begin
        we    = i_cmd.mem_we;
        waddr = r_dst;
        wdata = r_rdata;
        case (i_cmd.wsel)
            imt_pkg::W_INPUT: begin
                we    = i_cmd.mem_we & idx_ok;
                waddr = imt_pkg::ADDR_W'(i_element_index);
                wdata = i_element_value;
            end
            imt_pkg::W_HELD: wdata = r_held;
            default: ;
        endcase
    end

    always_comb begin
        case (i_cmd.rsel)
            imt_pkg::R_INPUT: raddr = imt_pkg::ADDR_W'(i_element_index);
            imt_pkg::R_LEAD:  raddr = r_lead;
            default:          raddr = r_src;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[raddr];
        end
    end

    // One restoring division step per cycle yields p div R and p mod R.
    assign trial     = {r_rem, r_dvd[imt_pkg::ADDR_W-1]};
    assign trial_ge  = trial >= {1'b0, i_rows};
    assign trial_sub = trial - {1'b0, i_rows};
    assign src_next  = (imt_pkg::SIZE_W'(r_rem) * imt_pkg::SIZE_W'(i_cols))
                       + imt_pkg::SIZE_W'(r_quo);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en && i_cmd.rsel == imt_pkg::R_INPUT) begin
            r_rd_ok <= idx_ok;
        end
        if (i_cmd.held_load) begin
            r_held <= r_rdata;
        end
        if (i_cmd.cap_size) begin
            r_size <= imt_pkg::SIZE_W'(i_rows) * imt_pkg::SIZE_W'(i_cols);
        end
        if (i_cmd.lead_clr) begin
            r_lead <= '0;
        end else if (i_cmd.lead_inc) begin
            r_lead <= r_lead + 1'b1;
        end
        if (i_cmd.div_load) begin
            r_dvd <= i_cmd.div_sel_lead ? r_lead : r_src;
            r_quo <= '0;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[imt_pkg::ADDR_W-2:0], 1'b0};
            r_quo <= {r_quo[imt_pkg::ADDR_W-2:0], trial_ge};
            r_rem <= trial_ge ? trial_sub[imt_pkg::RC_W-1:0] : trial[imt_pkg::RC_W-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.src_load) begin
            r_src <= src_next[imt_pkg::ADDR_W-1:0];
        end
        if (i_cmd.dst_load_lead) begin
            r_dst <= r_lead;
        end else if (i_cmd.dst_load_src) begin
            r_dst <= r_src;
        end
        if (i_cmd.emit) begin
            r_status <= i_cmd.emit_status;
            r_value  <= (i_cmd.emit_status == imt_pkg::STAT_READ && r_rd_ok) ? r_rdata : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    assign o_stat.size_big    = r_size > imt_pkg::SIZE_W'(imt_pkg::STORE_DEPTH);
    assign o_stat.size_tiny   = r_size <= imt_pkg::SIZE_W'(1);
    assign o_stat.div_last    = r_cnt == imt_pkg::CNT_W'(imt_pkg::ADDR_W - 1);
    assign o_stat.src_gt_lead = r_src > r_lead;
    assign o_stat.src_eq_lead = r_src == r_lead;
    assign o_stat.lead_last   = imt_pkg::SIZE_W'(r_lead) == r_size - 1'b1;

    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_read_value = r_value;

`ifndef SYNTHESIS
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("result strobe held for two cycles");
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_status != imt_pkg::STAT_READ) |-> r_value == '0)
        else $error("nonzero value on a transpose result");
    a_src_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.src_load) |-> imt_pkg::SIZE_W'(r_src) < r_size)
        else $error("source position outside the matrix");
`endif

endmodule
`default_nettype wire

>>> design/imt_ctrl.sv
// Controller state machine: sequences element accesses and the cycle-leader transpose.
`default_nettype none
module imt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire logic [1:0]        i_action,
    output logic                   busy,
    output imt_pkg::t_dp_cmd       o_cmd,
    input  wire imt_pkg::t_dp_stat i_stat
);

    imt_pkg::t_state r_state, n_state;
    logic            r_rot, n_rot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= imt_pkg::S_IDLE;
            r_rot   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rot   <= n_rot;
        end
    end

    always_comb begin
        n_state = r_state;
        n_rot   = r_rot;
        unique case (r_state)
            imt_pkg::S_IDLE: begin
                if (start && i_action == imt_pkg::ACT_READ) begin
                    n_state = imt_pkg::S_READ;
                end else if (start && i_action == imt_pkg::ACT_TRANSPOSE) begin
                    n_state = imt_pkg::S_SIZE;
                end
            end
            imt_pkg::S_READ:  n_state = imt_pkg::S_IDLE;
            imt_pkg::S_SIZE:  n_state = imt_pkg::S_CHECK;
            imt_pkg::S_CHECK: begin
                n_state = (i_stat.size_big || i_stat.size_tiny) ? imt_pkg::S_IDLE
                                                                 : imt_pkg::S_LEAD;
            end
            imt_pkg::S_LEAD: begin
                n_rot   = 1'b0;
                n_state = imt_pkg::S_DIV;
            end
            imt_pkg::S_DIV: begin
                if (i_stat.div_last) begin
                    n_state = imt_pkg::S_MUL;
                end
            end
            imt_pkg::S_MUL: n_state = r_rot ? imt_pkg::S_ROT_CHK : imt_pkg::S_SEARCH;
            imt_pkg::S_SEARCH: begin
                if (i_stat.src_gt_lead) begin
                    n_state = imt_pkg::S_DIV;
                end else if (i_stat.src_eq_lead) begin
                    n_rot   = 1'b1;
                    n_state = imt_pkg::S_HOLD_RD;
                end else begin
                    n_state = imt_pkg::S_NEXT;
                end
            end
            imt_pkg::S_HOLD_RD: n_state = imt_pkg::S_HOLD;
            imt_pkg::S_HOLD:    n_state = imt_pkg::S_DIV;
            imt_pkg::S_ROT_CHK: begin
                n_state = i_stat.src_eq_lead ? imt_pkg::S_LAST_WR : imt_pkg::S_MOVE_WR;
            end
            imt_pkg::S_MOVE_WR: n_state = imt_pkg::S_DIV;
            imt_pkg::S_LAST_WR: n_state = imt_pkg::S_NEXT;
            imt_pkg::S_NEXT: begin
                n_state = i_stat.lead_last ? imt_pkg::S_IDLE : imt_pkg::S_LEAD;
            end
            default: n_state = imt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.wsel        = imt_pkg::W_INPUT;
        o_cmd.rsel        = imt_pkg::R_INPUT;
        o_cmd.emit_status = imt_pkg::STAT_DONE;
        unique case (r_state)
            imt_pkg::S_IDLE: begin
                o_cmd.mem_we = start && i_action == imt_pkg::ACT_WRITE;
                o_cmd.rd_en  = start && i_action == imt_pkg::ACT_READ;
            end
            imt_pkg::S_READ: begin
                o_cmd.emit        = 1'b1;
                o_cmd.emit_status = imt_pkg::STAT_READ;
            end
            imt_pkg::S_SIZE: o_cmd.cap_size = 1'b1;
            imt_pkg::S_CHECK: begin
                o_cmd.lead_clr    = 1'b1;
                o_cmd.emit        = i_stat.size_big || i_stat.size_tiny;
                o_cmd.emit_status = i_stat.size_big ? imt_pkg::STAT_SIZE : imt_pkg::STAT_DONE;
            end
            imt_pkg::S_LEAD: begin
                o_cmd.div_load     = 1'b1;
                o_cmd.div_sel_lead = 1'b1;
            end
            imt_pkg::S_DIV: o_cmd.div_step = 1'b1;
            imt_pkg::S_MUL: o_cmd.src_load = 1'b1;
            imt_pkg::S_SEARCH: o_cmd.div_load = i_stat.src_gt_lead;
            imt_pkg::S_HOLD_RD: begin
                o_cmd.rd_en         = 1'b1;
                o_cmd.rsel          = imt_pkg::R_LEAD;
                o_cmd.dst_load_lead = 1'b1;
            end
            imt_pkg::S_HOLD: begin
                o_cmd.held_load    = 1'b1;
                o_cmd.div_load     = 1'b1;
                o_cmd.div_sel_lead = 1'b1;
            end
            imt_pkg::S_ROT_CHK: begin
                o_cmd.rd_en = !i_stat.src_eq_lead;
                o_cmd.rsel  = imt_pkg::R_SRC;
            end
            imt_pkg::S_MOVE_WR: begin
                o_cmd.mem_we       = 1'b1;
                o_cmd.wsel         = imt_pkg::W_MOVE;
                o_cmd.dst_load_src = 1'b1;
                o_cmd.div_load     = 1'b1;
            end
            imt_pkg::S_LAST_WR: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.wsel   = imt_pkg::W_HELD;
            end
            imt_pkg::S_NEXT: begin
                o_cmd.lead_inc = !i_stat.lead_last;
                o_cmd.emit     = i_stat.lead_last;
            end
            default: ;
        endcase
    end

    assign busy = r_state != imt_pkg::S_IDLE;

`ifndef SYNTHESIS
    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == imt_pkg::S_DIV && !i_stat.div_last) |=> r_state == imt_pkg::S_DIV)
        else $error("division left before its last step");
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_state == imt_pkg::S_IDLE)
        else $error("result issued without returning to idle");
    a_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == imt_pkg::S_SEARCH && i_stat.src_gt_lead) |=> r_state == imt_pkg::S_DIV)
        else $error("cycle walk not continued");
`endif

endmodule
`default_nettype wire

>>> design/in_place_matrix_transpose_unit.sv
// Top level of the in-place transpose unit: register file, controller and datapath.
//
//  Channel   Handshake            Payload
//  command   start / busy         i_action, i_element_index, i_element_value
//  result    o_strobe (1 cycle)   o_status, o_read_value
//  config    APB psel/penable     pwdata -> rows (0x0), cols (0x4)
//
// A write goes into the store when accepted; a read passes the read-data register and the
// READ state before the result strobe. A transpose first captures the size (SIZE) and checks
// it (CHECK), which alone ends a tiny or oversize transpose. Every step of a cycle walk runs
// the shared bit-serial divider, a step that moves a word adds a store write, and each leader
// adds the LEAD and NEXT states, so the total follows the number of walk steps, between R*C and (R*C)^2.
// Reset is synchronous and active low; the store is not cleared.
// busy is high while a transaction is in flight; results cannot be stalled.
`default_nettype none
module in_place_matrix_transpose_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [1:0]                         i_action,
    input  wire logic [imt_pkg::IDX_W-1:0]          i_element_index,
    input  wire logic signed [imt_pkg::DATA_W-1:0]  i_element_value,
    output logic                                    o_strobe,
    output logic [1:0]                              o_status,
    output logic signed [imt_pkg::DATA_W-1:0]       o_read_value,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [2:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);

    logic [imt_pkg::RC_W-1:0] r_rows;
    logic [imt_pkg::RC_W-1:0] r_cols;
    logic                     cfg_wr;
    imt_pkg::t_dp_cmd         cmd;
    imt_pkg::t_dp_stat        stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= imt_pkg::RC_W'(1);
            r_cols <= imt_pkg::RC_W'(1);
        end else if (cfg_wr) begin
            if (paddr[2] == imt_pkg::REG_ROWS) begin
                r_rows <= pwdata[imt_pkg::RC_W-1:0];
            end else begin
                r_cols <= pwdata[imt_pkg::RC_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == imt_pkg::REG_ROWS) ? 32'(r_rows) : 32'(r_cols);

    imt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .busy     (busy),
        .o_cmd    (cmd),
        .i_stat   (stat)
    );

    imt_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_rows          (r_rows),
        .i_cols          (r_cols),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_read_value    (o_read_value)
    );

endmodule
`default_nettype wire

>>> bench/in_place_matrix_transpose_unit_tb.sv
// Self-checking bench for the in-place transpose unit: element traffic, transposes and register writes.
`timescale 1ns / 100ps
module in_place_matrix_transpose_unit_tb;

    localparam logic [2:0] ADDR_ROWS = 3'd0;
    localparam logic [2:0] ADDR_COLS = 3'd4;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 300000;

    typedef enum logic {K_CMD, K_REG} t_kind;

    typedef struct {
        t_kind       kind;
        logic [1:0]  action;
        logic [9:0]  index;
        logic [63:0] value;
        logic [2:0]  addr;
        logic [31:0] data;
    } t_pending;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] value;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] i_action = '0;
    logic [imt_pkg::IDX_W-1:0] i_element_index = '0;
    logic signed [imt_pkg::DATA_W-1:0] i_element_value = '0;
    logic o_strobe;
    logic [1:0] o_status;
    logic signed [imt_pkg::DATA_W-1:0] o_read_value;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    in_place_matrix_transpose_unit dut (.*);

    always #6 i_clk = ~i_clk;

    t_pending pending_q[$];
    t_outcome awaited_q[$];
    logic [63:0] shadow_store [imt_pkg::STORE_DEPTH];
    logic [imt_pkg::RC_W-1:0] rows_q = 11'd1, cols_q = 11'd1;
    bit filled [imt_pkg::STORE_DEPTH];
    int errors = 0, gen_items = 0, accepted = 0, results_seen = 0;
    int transposes_done = 0, size_errors = 0, reg_writes = 0;
    int quiet = 0, stall = 0;

    function automatic int unsigned source_pos(int unsigned p, int unsigned r, int unsigned c);
        return (p % r) * c + p / r;
    endfunction

    // Rotates every permutation cycle once, starting from its smallest position.
    task automatic rotate_cycles(int unsigned r, int unsigned c);
        int unsigned n, lead, src, dst;
        logic [63:0] held;
        n = r * c;
        for (lead = 0; lead < n; lead++) begin
            src = source_pos(lead, r, c);
            while (src > lead) src = source_pos(src, r, c);
            if (src == lead) begin
                held = shadow_store[lead];
                dst = lead;
                src = source_pos(dst, r, c);
                while (src != lead) begin
                    shadow_store[dst] = shadow_store[src];
                    dst = src;
                    src = source_pos(dst, r, c);
                end
                shadow_store[dst] = held;
            end
        end
    endtask

    task automatic predict_command(t_pending it);
        int unsigned n;
        t_outcome o;
        n = rows_q * cols_q;
        o.value = '0;
        case (it.action)
            imt_pkg::ACT_WRITE: shadow_store[it.index] = it.value;
            imt_pkg::ACT_READ: begin
                o.status = imt_pkg::STAT_READ;
                o.value = shadow_store[it.index];
                awaited_q.push_back(o);
            end
            imt_pkg::ACT_TRANSPOSE: begin
                if (n > imt_pkg::STORE_DEPTH) begin
                    o.status = imt_pkg::STAT_SIZE;
                    size_errors++;
                end else begin
                    if (n > 1) rotate_cycles(rows_q, cols_q);
                    o.status = imt_pkg::STAT_DONE;
                    transposes_done++;
                end
                awaited_q.push_back(o);
            end
            default: ;
        endcase
    endtask

    // Driver: commands go out after random gaps, back to back in one stretch, register writes only while idle.
    always @(posedge i_clk) begin
        logic nx_start, nx_psel, nx_pen, no_idle;
        t_pending it;
        nx_start = start;
        nx_psel = psel;
        nx_pen = penable;
        no_idle = (accepted >= 100 && accepted < 170);
        if (i_rst_n) begin
            if (start && !busy) begin
                it.kind = K_CMD;
                it.action = i_action;
                it.index = i_element_index;
                it.value = i_element_value;
                predict_command(it);
                accepted++;
                nx_start = 1'b0;
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_ROWS) rows_q = pwdata[imt_pkg::RC_W-1:0];
                else if (paddr == ADDR_COLS) cols_q = pwdata[imt_pkg::RC_W-1:0];
                reg_writes++;
                nx_psel = 1'b0;
                nx_pen = 1'b0;
            end else if (psel) begin
                nx_pen = 1'b1;
            end
            quiet = ((start && !busy) || busy || awaited_q.size() != 0 || start) ? 0 : quiet + 1;
            if (!nx_start && !nx_psel && pending_q.size() != 0) begin
                if (pending_q[0].kind == K_REG) begin
                    if (quiet >= 4 && awaited_q.size() == 0) begin
                        it = pending_q.pop_front();
                        nx_psel = 1'b1;
                        paddr <= it.addr;
                        pwdata <= it.data;
                        pwrite <= 1'b1;
                    end
                end else if (no_idle || $urandom_range(99) >= 9) begin
                    it = pending_q.pop_front();
                    nx_start = 1'b1;
                    i_action <= it.action;
                    i_element_index <= it.index;
                    i_element_value <= it.value;
                end
            end
        end
        start <= nx_start;
        psel <= nx_psel;
        penable <= nx_pen;
    end

    // Monitor: every result strobe is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_outcome o;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (awaited_q.size() == 0) begin
                $display("%0t: unexpected result status=%0d value=%h", $realtime, o_status,
                         o_read_value);
                errors++;
            end else begin
                o = awaited_q.pop_front();
                if (o_status !== o.status) begin
                    $display("%0t: status mismatch expected %0d actual %0d", $realtime,
                             o.status, o_status);
                    errors++;
                end
                if (o_read_value !== o.value) begin
                    $display("%0t: read_value mismatch expected %h actual %h", $realtime,
                             o.value, o_read_value);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which no transaction of any kind completes.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (psel && penable)) stall <= 0;
        else stall <= stall + 1;
        if (stall >= STALL_LIMIT) begin
            $display("Timeout after %0d cycles without a transaction", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_command(logic [1:0] act, logic [9:0] idx, logic [63:0] val);
        t_pending it;
        it.kind = K_CMD;
        it.action = act;
        it.index = idx;
        it.value = val;
        it.addr = '0;
        it.data = '0;
        pending_q.push_back(it);
        if (act == imt_pkg::ACT_WRITE) filled[idx] = 1'b1;
        if (act != ACT_UNUSED) gen_items++;
    endtask

    task automatic push_reg_write(logic [2:0] addr, logic [31:0] data);
        t_pending it;
        it.kind = K_REG;
        it.action = imt_pkg::ACT_WRITE;
        it.index = '0;
        it.value = '0;
        it.addr = addr;
        it.data = data;
        pending_q.push_back(it);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(7))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic read_some_filled();
        int unsigned k;
        repeat (20) begin
            k = $urandom_range(imt_pkg::STORE_DEPTH - 1);
            if (filled[k]) begin
                push_command(imt_pkg::ACT_READ, k, '0);
                return;
            end
        end
    endtask

    initial begin
        int unsigned r, c, n, i;
        // Directed part: field extremes, unused action, tiny and oversize transposes.
        push_command(imt_pkg::ACT_WRITE, 10'd0, 64'h8000_0000_0000_0000);
        push_command(imt_pkg::ACT_WRITE, 10'd1023, 64'h7FFF_FFFF_FFFF_FFFF);
        push_command(imt_pkg::ACT_WRITE, 10'd1, '1);
        push_command(imt_pkg::ACT_READ, 10'd1023, '0);
        push_command(imt_pkg::ACT_READ, 10'd0, '0);
        push_command(imt_pkg::ACT_READ, 10'd1, '0);
        push_command(ACT_UNUSED, 10'h3FF, '1);
        push_command(imt_pkg::ACT_READ, 10'd1023, '0);
        push_command(imt_pkg::ACT_TRANSPOSE, 10'd0, '0);
        push_command(imt_pkg::ACT_READ, 10'd0, '0);
        push_reg_write(ADDR_ROWS, 32'd0);
        push_command(imt_pkg::ACT_TRANSPOSE, 10'd0, '0);
        push_reg_write(ADDR_ROWS, 32'hFFFF_FFFF);
        push_reg_write(ADDR_COLS, 32'd2047);
        push_command(imt_pkg::ACT_TRANSPOSE, 10'd0, '0);
        push_reg_write(ADDR_ROWS, 32'd1025);
        push_reg_write(ADDR_COLS, 32'd1);
        push_command(imt_pkg::ACT_TRANSPOSE, 10'd0, '0);
        push_reg_write(ADDR_ROWS, 32'd1024);
        push_reg_write(ADDR_COLS, 32'd1024);
        push_command(imt_pkg::ACT_TRANSPOSE, 10'd0, '0);
        push_command(imt_pkg::ACT_READ, 10'd1, '0);

        // Random part: fill a small matrix, transpose it, read some of it back, sometimes undo it.
        while (gen_items < 270) begin
            r = $urandom_range(1, 7);
            c = $urandom_range(1, 9);
            n = r * c;
            push_reg_write(ADDR_ROWS, r | ($urandom & 32'hFFFF_F800));
            push_reg_write(ADDR_COLS, c | ($urandom & 32'hFFFF_F800));
            for (i = 0; i < n; i++) push_command(imt_pkg::ACT_WRITE, i, rand_word());
            if ($urandom_range(2) == 0) read_some_filled();
            push_command(imt_pkg::ACT_TRANSPOSE, $urandom, {$urandom, $urandom});
            if ($urandom_range(3) == 0) push_command(imt_pkg::ACT_TRANSPOSE, 10'd0, '0);
            repeat ((n + 1) / 2) push_command(imt_pkg::ACT_READ, $urandom_range(n - 1), '0);
            repeat ($urandom_range(3)) begin
                case ($urandom_range(3))
                    0: push_command(ACT_UNUSED, $urandom, {$urandom, $urandom});
                    1: push_command(imt_pkg::ACT_WRITE, $urandom, rand_word());
                    default: read_some_filled();
                endcase
            end
            if ($urandom_range(2) == 0) begin
                // The bench swaps the dimensions, so a further transpose undoes the last one.
                push_reg_write(ADDR_ROWS, c);
                push_reg_write(ADDR_COLS, r);
                push_command(imt_pkg::ACT_TRANSPOSE, 10'd0, '0);
                repeat (3) push_command(imt_pkg::ACT_READ, $urandom_range(n - 1), '0);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_q.size() == 0 && awaited_q.size() == 0 && !start && !busy);
        repeat (20) @(posedge i_clk);
        $display("Covered %0d commands, %0d results, %0d register writes,", accepted,
                 results_seen, reg_writes);
        $display("including %0d transposes and %0d size rejections.", transposes_done,
                 size_errors);
        if (errors == 0 && awaited_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
